@@ hw/rtl/bcdalu_pkg.sv @@
// package for the bcd-capable accumulator alu
// holds the opcode enum, the architectural state struct and shared constants
// no dependencies
`default_nettype none

package bcdalu_pkg;

	typedef enum logic [3:0] {
		OP_ADC = 4'd0,
		OP_SBC = 4'd1,
		OP_AND = 4'd2,
		OP_EOR = 4'd3,
		OP_ORA = 4'd4,
		OP_BIT = 4'd5,
		OP_CLC = 4'd6,
		OP_SEC = 4'd7,
		OP_CLD = 4'd8,
		OP_SED = 4'd9,
		OP_CLV = 4'd10
	} op_t;

	typedef struct packed {
		logic [7:0] acc;
		logic       c;
		logic       z;
		logic       v;
		logic       n;
		logic       d;
	} alu_state_t;

	localparam logic [3:0]  DEC_DIGIT_MAX = 4'd9;
	localparam logic [9:0]  DEC_BYTE_MAX  = 10'h099;
	localparam logic [15:0] DEC_WORD_MAX  = 16'h0099;
	localparam logic [9:0]  ADD_LO_ADJ    = 10'd6;
	localparam logic [9:0]  ADD_HI_ADJ    = 10'd96;
	localparam logic [15:0] SUB_LO_ADJ    = 16'd6;
	localparam logic [15:0] SUB_HI_ADJ    = 16'h0060;

endpackage

`default_nettype wire

@@ hw/rtl/bcdalu_core.sv @@
// combinational datapath: next accumulator and flags for one operation
// depends on bcdalu_pkg
`default_nettype none

module bcdalu_core (
	input  wire logic [3:0]             op,
	input  wire logic [7:0]             operand,
	input  wire bcdalu_pkg::alu_state_t cur,
	output bcdalu_pkg::alu_state_t      nxt
);
	import bcdalu_pkg::*;

	logic [7:0]  a;
	logic        cin;
	logic        borrow;
	// add path
	logic [9:0]  add_s1;
	logic [9:0]  add_s2;
	logic [9:0]  add_s3;
	logic [4:0]  add_lo;
	// subtract path
	logic [15:0] sub_r1;
	logic [15:0] sub_r2;
	logic [15:0] sub_r3;
	logic [4:0]  sub_lo_a;
	logic [4:0]  sub_lo_m;
	logic [7:0]  logic_res;

	assign a      = cur.acc;
	assign cin    = cur.c;
	assign borrow = ~cur.c;

	// decimal add: low digit fix then high digit fix
	assign add_s1 = {2'b00, a} + {2'b00, operand} + {9'd0, cin};
	assign add_lo = {1'b0, a[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin};
	assign add_s2 = (add_lo > {1'b0, DEC_DIGIT_MAX}) ? add_s1 + ADD_LO_ADJ : add_s1;
	assign add_s3 = (add_s2 > DEC_BYTE_MAX) ? add_s2 + ADD_HI_ADJ : add_s2;

	// 16-bit wrapping subtract with decimal fix
	assign sub_r1   = {8'd0, a} - {8'd0, operand} - {15'd0, borrow};
	assign sub_lo_a = {1'b0, a[3:0]};
	assign sub_lo_m = {1'b0, operand[3:0]} + {4'd0, borrow};
	assign sub_r2   = (sub_lo_a < sub_lo_m) ? sub_r1 - SUB_LO_ADJ : sub_r1;
	assign sub_r3   = (sub_r2 > DEC_WORD_MAX) ? sub_r2 - SUB_HI_ADJ : sub_r2;

	always_comb begin
		nxt       = cur;
		logic_res = a;
		case (op_t'(op))
			OP_ADC: begin
				nxt.z = (add_s1[7:0] == 8'd0);
				if (cur.d) begin
					nxt.n   = add_s2[7];
					nxt.v   = ~(a[7] ^ operand[7]) & (a[7] ^ add_s2[7]);
					nxt.c   = (add_s3 > DEC_BYTE_MAX);
					nxt.acc = add_s3[7:0];
				end else begin
					nxt.n   = add_s1[7];
					nxt.v   = ~(a[7] ^ operand[7]) & (a[7] ^ add_s1[7]);
					nxt.c   = add_s1[8];
					nxt.acc = add_s1[7:0];
				end
			end
			OP_SBC: begin
				nxt.z = (sub_r1[7:0] == 8'd0);
				nxt.v = (a[7] ^ operand[7]) & (a[7] ^ sub_r1[7]);
				nxt.n = sub_r1[7];
				if (cur.d) begin
					nxt.c   = (sub_r3[15:8] == 8'd0);
					nxt.acc = sub_r3[7:0];
				end else begin
					nxt.c   = (sub_r1[15:8] == 8'd0);
					nxt.acc = sub_r1[7:0];
				end
			end
			OP_AND, OP_EOR, OP_ORA: begin
				case (op_t'(op))
					OP_AND:  logic_res = a & operand;
					OP_EOR:  logic_res = a ^ operand;
					default: logic_res = a | operand;
				endcase
				nxt.acc = logic_res;
				nxt.z   = (logic_res == 8'd0);
				nxt.n   = logic_res[7];
			end
			OP_BIT: begin
				nxt.n = operand[7];
				nxt.v = operand[6];
				nxt.z = ((a & operand) == 8'd0);
			end
			OP_CLC:  nxt.c = 1'b0;
			OP_SEC:  nxt.c = 1'b1;
			OP_CLD:  nxt.d = 1'b0;
			OP_SED:  nxt.d = 1'b1;
			OP_CLV:  nxt.v = 1'b0;
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/bcd_capable_accumulator_alu.sv @@
// top level of the bcd-capable accumulator alu
// input register, datapath (bcdalu_core), architectural state and result register
// depends on bcdalu_pkg and bcdalu_core
`default_nettype none

// usage
// - input channel: op and operand, one transfer per cycle when in_valid and in_ready
// - output channel: acc_out and the five flags, one transfer per accepted item
// - an accepted item lands in the input register; when it advances, the datapath
//   result is written to the result register and to the accumulator and flags,
//   and out_valid rises with the loaded result register
// - throughput: one item per cycle while the receiver takes results; the only loop is
//   accumulator/flags back into the combinational datapath, closed by the state register
// - in_ready stays high while the input register is empty or the result register is
//   free or being drained, so a new item is taken while a finished result still waits
// - receiver stall: the result register holds, the input register holds its item,
//   and in_ready drops once the input register is full, until the result is taken
// - reset: accumulator and all flags clear to zero, both stages empty
// - opcodes above clear overflow change nothing but still return a result
module bcd_capable_accumulator_alu (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] op,
	input  wire logic [7:0] operand,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      acc_out,
	output logic            carry_out,
	output logic            zero_out,
	output logic            overflow_out,
	output logic            negative_out,
	output logic            decimal_out
);
	import bcdalu_pkg::*;

	// input stage
	logic       valid_s1;
	logic [3:0] op_s1;
	logic [7:0] operand_s1;
	// result stage
	logic       valid_s2;
	alu_state_t res_s2;
	// architectural accumulator and flags
	alu_state_t state_q;
	alu_state_t state_nxt;

	logic advance;
	logic in_xfer;

	// stage 1 moves on when the result register is empty or drains this cycle
	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_xfer  = in_valid & in_ready;

	bcdalu_core u_core (
		.op      (op_s1),
		.operand (operand_s1),
		.cur     (state_q),
		.nxt     (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1      <= op;
			operand_s1 <= operand;
		end
		if (advance) begin
			res_s2 <= state_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign acc_out      = res_s2.acc;
	assign carry_out    = res_s2.c;
	assign zero_out     = res_s2.z;
	assign overflow_out = res_s2.v;
	assign negative_out = res_s2.n;
	assign decimal_out  = res_s2.d;

endmodule

`default_nettype wire
